// File: hw/rtl/cvd_pkg.sv
// shared types and constants for the coefficient vector dedup table
// used by every module of the block; no dependencies
`default_nettype none

package cvd_pkg;

  localparam int COEFS_PER_VECTOR = 20;
  localparam int TABLE_ENTRIES    = 256;
  localparam int QUEUE_DEPTH      = 2;

  localparam int WORD_W  = 32;
  localparam int VEC_W   = COEFS_PER_VECTOR * WORD_W;
  localparam int POS_W   = $clog2(COEFS_PER_VECTOR + 1);
  localparam int WIDX_W  = (COEFS_PER_VECTOR > 1) ? $clog2(COEFS_PER_VECTOR) : 1;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int MAT_W   = 8;
  localparam int SURF_W  = 32;
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COEFS_PER_VECTOR-1:0][WORD_W-1:0] vec_t;

  typedef struct packed {
    logic overflow;
    vec_t vec;
  } q_entry_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_FULL     = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DECIDE,
    B_EMIT
  } back_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/cvd_front.sv
// front end: gathers coefficient words into a vector and hands finished
// vectors to the queue; depends on cvd_pkg
`default_nettype none

module cvd_front
  import cvd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WORD_W-1:0] coef_word,
  input  wire logic              last_word,
  input  wire logic              q_full,
  output logic                   q_push,
  output q_entry_t               q_push_data
);

  vec_t             vec;
  vec_t             vec_next;
  logic [POS_W-1:0] pos;
  logic             ovf;
  logic             in_range;
  logic             accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign in_range = pos < POS_W'(COEFS_PER_VECTOR);

  always_comb begin
    vec_next = vec;
    if (in_range) begin
      vec_next[pos[WIDX_W-1:0]] = coef_word;
    end
  end

  assign q_push               = accept && last_word;
  assign q_push_data.vec      = vec_next;
  assign q_push_data.overflow = ovf || !in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      vec <= '0;
      pos <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      if (last_word) begin
        // unsent trailing words must read as zero for the next vector
        vec <= '0;
        pos <= '0;
        ovf <= 1'b0;
      end else begin
        vec <= vec_next;
        if (in_range) begin
          pos <= pos + POS_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cvd_queue.sv
// short fifo of finished vectors between front and back end
// depends on cvd_pkg
`default_nettype none

module cvd_queue
  import cvd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  output logic          full,
  input  wire logic     pop,
  output q_entry_t      pop_data,
  output logic          empty
);

  q_entry_t          ent [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic              do_push;
  logic              do_pop;

  assign full     = cnt == QCNT_W'(QUEUE_DEPTH);
  assign empty    = cnt == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cvd_back.sv
// back end: searches the unique table row by row, appends new vectors and
// drives the registered result channel; depends on cvd_pkg
`default_nettype none

module cvd_back
  import cvd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  input  wire q_entry_t           q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [MAT_W-1:0]        material_index,
  output logic                    is_new_entry,
  output logic [SURF_W-1:0]       surface_number,
  output logic [1:0]              error_code
);

  // one row per stored vector
  logic [VEC_W-1:0]  mem [TABLE_ENTRIES];
  logic [VEC_W-1:0]  rd_data;

  back_state_t       state;
  back_state_t       state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  issue_idx;
  logic              rd_pend;
  logic [IDX_W-1:0]  rd_idx;
  logic [MAT_W-1:0]  res_index;
  logic              res_new;
  err_t              res_err;
  logic [SURF_W-1:0] surf;

  logic              hit;
  logic              has_room;
  logic              out_free;
  logic              mem_re;
  logic              mem_we;

  assign hit      = rd_pend && (rd_data == q_head.vec);
  assign has_room = count < CNT_W'(TABLE_ENTRIES);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_head.overflow) begin
            state_next = B_EMIT;
          end else if (count == '0) begin
            state_next = B_DECIDE;
          end else begin
            state_next = B_SCAN;
          end
        end
      end
      B_SCAN: begin
        if (hit) begin
          state_next = B_EMIT;
        end else if (!rd_pend && issue_idx == count) begin
          state_next = B_DECIDE;
        end
      end
      B_DECIDE: state_next = B_EMIT;
      B_EMIT: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    mem_re = 1'b0;
    mem_we = 1'b0;
    q_pop  = 1'b0;
    unique case (state)
      B_IDLE:   ;
      B_SCAN:   mem_re = (issue_idx < count) && !hit;
      B_DECIDE: mem_we = has_room;
      B_EMIT:   q_pop  = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IDX_W-1:0]] <= q_head.vec;
    end
    if (mem_re) begin
      rd_data <= mem[issue_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      count     <= '0;
      issue_idx <= '0;
      rd_pend   <= 1'b0;
      surf      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_IDLE) begin
        issue_idx <= '0;
        rd_pend   <= 1'b0;
      end
      if (state == B_SCAN) begin
        rd_pend <= mem_re;
        if (mem_re) begin
          issue_idx <= issue_idx + CNT_W'(1);
        end
      end
      if (mem_we) begin
        count <= count + CNT_W'(1);
      end
      if (q_pop) begin
        out_valid <= 1'b1;
        surf      <= surf + SURF_W'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (state == B_IDLE && !q_empty) begin
      res_index <= '0;
      res_new   <= 1'b0;
      res_err   <= q_head.overflow ? ERR_OVERFLOW : ERR_OK;
    end
    if (state == B_SCAN) begin
      rd_idx <= issue_idx[IDX_W-1:0];
      if (hit) begin
        res_index <= MAT_W'(rd_idx);
      end
    end
    if (state == B_DECIDE) begin
      if (has_room) begin
        res_index <= MAT_W'(count[IDX_W-1:0]);
        res_new   <= 1'b1;
      end else begin
        res_err <= ERR_FULL;
      end
    end
    if (q_pop) begin
      material_index <= res_index;
      is_new_entry   <= res_new;
      surface_number <= surf;
      error_code     <= res_err;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_ENTRIES))
    else $error("unique count beyond table size");

  a_busy_has_item: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCAN || state == B_DECIDE || state == B_EMIT) |-> !q_empty)
    else $error("back end working without a queued vector");

  a_new_is_ok: assert property (@(posedge clk) disable iff (rst)
    q_pop && res_new |-> res_err == ERR_OK)
    else $error("new entry reported with an error");

  a_overflow_clean: assert property (@(posedge clk) disable iff (rst)
    q_pop && res_err == ERR_OVERFLOW |-> !res_new && res_index == '0)
    else $error("overflow result carries an index");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> count == $past(count) + CNT_W'(1))
    else $error("append did not advance the count");

endmodule

`default_nettype wire

// File: hw/rtl/coefficient_vector_dedup_table_unit.sv
// top level of the coefficient vector dedup table: front end, vector queue,
// search and append back end; depends on cvd_pkg, cvd_front, cvd_queue, cvd_back
`default_nettype none

// channel | handshake             | payload
// in      | in_valid / in_stall   | coef_word, last_word
// out     | out_valid / out_stall | material_index, is_new_entry, surface_number, error_code
//
// words are taken one per cycle while in_stall is low; after a vector's last word the
// back end walks the stored entries, stopping at a match, one row per cycle
// through the single read port of the table memory, then registers the result.
// input stalls only while the two-vector queue is full; the result sits in an
// output register so the back end can start on the next vector meanwhile.
// synchronous reset empties the table count, queue and gathering buffer; no clearing pass.

module coefficient_vector_dedup_table_unit
  import cvd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [31:0]       coef_word,
  input  wire logic              last_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             material_index,
  output logic                   is_new_entry,
  output logic [31:0]            surface_number,
  output logic [1:0]             error_code
);

  q_entry_t push_data;
  q_entry_t head;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;

  cvd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .coef_word   (coef_word),
    .last_word   (last_word),
    .q_full      (full),
    .q_push      (push),
    .q_push_data (push_data)
  );

  cvd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  cvd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (empty),
    .q_head         (head),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .material_index (material_index),
    .is_new_entry   (is_new_entry),
    .surface_number (surface_number),
    .error_code     (error_code)
  );

endmodule

`default_nettype wire
